// ===== hw/rtl/wac_pkg.sv =====
// Shared types, opcodes and helper functions for the width-aware ALU.
// No dependencies; used by the front, queue, back and top-level modules.
package wac_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int HALF_WIDTH = MAX_WIDTH / 2;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int QDEPTH = 2;
  // Back pipeline length: one stage per quotient bit plus entry and output stages.
  localparam int NST = MAX_WIDTH + 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
    OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7, OP_SHL = 4'd8, OP_SHR = 4'd9
  } op_t;

  // One classified item as it passes from the front part to the back part.
  typedef struct packed {
    logic [3:0]           kind;
    logic [MAX_WIDTH-1:0] a;
    logic [MAX_WIDTH-1:0] b;
    logic [MAX_WIDTH-1:0] ma;
    logic [MAX_WIDTH-1:0] mb;
    logic [MAX_WIDTH-1:0] mask;
    logic [WW-1:0]        w;
    logic                 an;
    logic                 bn;
    logic                 unk;
    logic                 nuw;
    logic                 nsw;
    logic                 sgn;
  } item_t;

  // Bit length with the quirk that the value two counts as one bit.
  function automatic logic [WW-1:0] bit_len_est(input logic [MAX_WIDTH-1:0] v);
    logic [WW-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (v[i]) n = WW'(i + 1);
    end
    if (v == MAX_WIDTH'(2)) n = WW'(1);
    return n;
  endfunction

endpackage

// ===== hw/rtl/width_aware_alu_with_wrap_checks_top.sv =====
// Width-aware integer ALU with no-wrap checks, top level.
// Depends on wac_pkg, wac_front, wac_queue and wac_back.
//
// Usage: the input channel (valid/ready) carries one operation per transfer:
// opcode, two operands with known flags, a width from 1 to 64 and the wrap
// and signed flags. The output channel (out_valid/out_ready) returns one
// result per transfer: the value masked to the width and an unknown flag.
// Results come back in order, one per input transfer.
// From input transfer to output valid, the front register loads at the transfer
// edge, the queue registers the item, and then it passes the 66-stage back
// pipeline, whose length is set by the pipelined divider.
// Throughput is one operation per cycle when the receiver keeps ready high.
// While a result waits with out_ready low the back pipeline holds, the
// two-entry queue fills and then the front stops taking input. Reset empties
// all stages and the queue; no results are pending afterward.
module width_aware_alu_with_wrap_checks_top import wac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  kind,
  input  logic [63:0] lhs_value,
  input  logic [63:0] rhs_value,
  input  logic        lhs_known,
  input  logic        rhs_known,
  input  logic [6:0]  bit_width,
  input  logic        no_unsigned_wrap,
  input  logic        no_signed_wrap,
  input  logic        signed_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_value,
  output logic        result_unknown
);

  logic  fv, fready, qv, qready;
  item_t fitem, qitem;

  wac_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .kind(kind),
    .lhs_value(lhs_value), .rhs_value(rhs_value), .lhs_known(lhs_known),
    .rhs_known(rhs_known), .bit_width(bit_width),
    .no_unsigned_wrap(no_unsigned_wrap), .no_signed_wrap(no_signed_wrap),
    .signed_mode(signed_mode), .fv(fv), .fready(fready), .fitem(fitem)
  );

  wac_queue u_queue (
    .clk(clk), .rst(rst), .iv(fv), .iready(fready), .idata(fitem),
    .ov(qv), .oready(qready), .odata(qitem)
  );

  wac_back u_back (
    .clk(clk), .rst(rst), .iv(qv), .iready(qready), .idata(qitem),
    .ov(out_valid), .oready(out_ready), .oval(result_value), .ounk(result_unknown)
  );

endmodule

// ===== hw/rtl/wac_front.sv =====
// Front part: clamps the width, masks operands and forms magnitudes.
// Depends on wac_pkg.
module wac_front import wac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  logic [3:0]           kind,
  input  logic [63:0]          lhs_value,
  input  logic [63:0]          rhs_value,
  input  logic                 lhs_known,
  input  logic                 rhs_known,
  input  logic [6:0]           bit_width,
  input  logic                 no_unsigned_wrap,
  input  logic                 no_signed_wrap,
  input  logic                 signed_mode,
  output logic                 fv,
  input  logic                 fready,
  output item_t                fitem
);

  item_t         item_next;
  logic [WW-1:0] w;
  logic [MAX_WIDTH-1:0] mask, sbit;

  assign ready = !fv || fready;

  always_comb begin
    if (bit_width == 7'd0) w = WW'(1);
    else if (bit_width > 7'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(bit_width);
    mask = {MAX_WIDTH{1'b1}} >> (WW'(MAX_WIDTH) - w);
    sbit = MAX_WIDTH'(1) << (w - WW'(1));
    item_next.kind = kind;
    item_next.w    = w;
    item_next.mask = mask;
    item_next.a    = lhs_value[MAX_WIDTH-1:0] & mask;
    item_next.b    = rhs_value[MAX_WIDTH-1:0] & mask;
    item_next.an   = |(item_next.a & sbit);
    item_next.bn   = |(item_next.b & sbit);
    // Negating the minimum value leaves it unchanged, which is its magnitude.
    item_next.ma   = item_next.an ? ((~item_next.a + MAX_WIDTH'(1)) & mask) : item_next.a;
    item_next.mb   = item_next.bn ? ((~item_next.b + MAX_WIDTH'(1)) & mask) : item_next.b;
    if (item_next.an && item_next.ma == '0) item_next.ma = sbit;
    if (item_next.bn && item_next.mb == '0) item_next.mb = sbit;
    item_next.unk  = !lhs_known || !rhs_known || (kind > 4'(OP_SHR));
    item_next.nuw  = no_unsigned_wrap;
    item_next.nsw  = no_signed_wrap;
    item_next.sgn  = signed_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (ready) begin
      fv <= valid;
    end
    if (ready && valid) fitem <= item_next;
  end

endmodule

// ===== hw/rtl/wac_queue.sv =====
// Short queue between the front and back parts.
// Depends on wac_pkg.
module wac_queue import wac_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  iv,
  output logic  iready,
  input  item_t idata,
  output logic  ov,
  input  logic  oready,
  output item_t odata
);

  item_t mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp, rp;
  logic [$clog2(QDEPTH):0]   cnt;
  logic push, pop;

  assign iready = cnt != ($clog2(QDEPTH)+1)'(QDEPTH);
  assign ov     = cnt != '0;
  assign odata  = mem[rp];
  assign push   = iv && iready;
  assign pop    = ov && oready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
    end
    if (push) mem[wp] <= idata;
  end

endmodule

// ===== hw/rtl/wac_divider.sv =====
// Pipelined radix-2 divider, one quotient bit per stage.
// Depends on wac_pkg.
module wac_divider import wac_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MAX_WIDTH-1:0] num,
  input  logic [MAX_WIDTH-1:0] den,
  output logic [MAX_WIDTH-1:0] quo,
  output logic [MAX_WIDTH-1:0] rem
);

  logic [MAX_WIDTH-1:0] q [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] r [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] d [MAX_WIDTH+1];

  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;

  for (genvar s = 0; s < MAX_WIDTH; s++) begin : g_stage
    logic [MAX_WIDTH:0] t;
    logic [MAX_WIDTH:0] diff;
    logic [MAX_WIDTH-1:0] qs, rs, ds;
    assign t = {r[s], q[s][MAX_WIDTH-1]};
    assign diff = t - {1'b0, d[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        qs <= {q[s][MAX_WIDTH-2:0], !diff[MAX_WIDTH]};
        rs <= diff[MAX_WIDTH] ? t[MAX_WIDTH-1:0] : diff[MAX_WIDTH-1:0];
        ds <= d[s];
      end
    end
    assign q[s+1] = qs;
    assign r[s+1] = rs;
    assign d[s+1] = ds;
  end

  assign quo = q[MAX_WIDTH];
  assign rem = r[MAX_WIDTH];

endmodule

// ===== hw/rtl/wac_back.sv =====
// Back part: stalling pipeline that computes the operation and checks.
// Depends on wac_pkg and wac_divider.
module wac_back import wac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 iv,
  output logic                 iready,
  input  item_t                idata,
  output logic                 ov,
  input  logic                 oready,
  output logic [MAX_WIDTH-1:0] oval,
  output logic                 ounk
);

  // Stage-0 result: everything but division, which runs through the divider.
  // A product is carried as its low half-width product and two cross terms,
  // which are summed at the output stage.
  typedef struct packed {
    logic [MAX_WIDTH-1:0]  res;
    logic [HALF_WIDTH-1:0] pc1;
    logic [HALF_WIDTH-1:0] pc2;
    logic [MAX_WIDTH-1:0]  mask;
    logic                  unk;
    logic                  ismul;
    logic                  isdiv;
    logic                  isquo;
    logic                  negq;
    logic                  negr;
    logic                  sgn;
  } st_t;

  st_t  st [NST-1];
  logic vld [NST];
  logic en;
  st_t  s0;
  logic [MAX_WIDTH-1:0] dnum, dden, quo, rem, dres, msum, mres;
  logic [HALF_WIDTH-1:0] al, ah, bl, bh;
  logic [MAX_WIDTH-1:0] sh;
  logic [WW:0] lsum;
  logic big;

  // Whole pipeline advances together; a stall at the output holds it.
  assign en = !vld[NST-1] || oready;
  assign iready = en;
  assign ov = vld[NST-1];

  always_comb begin
    s0 = '0;
    s0.mask = idata.mask;
    s0.unk = idata.unk;
    s0.sgn = idata.sgn;
    big = idata.b >= MAX_WIDTH'(idata.w);
    sh  = idata.b;
    msum = '0;
    lsum = '0;
    al = idata.a[HALF_WIDTH-1:0];
    ah = idata.a[MAX_WIDTH-1:HALF_WIDTH];
    bl = idata.b[HALF_WIDTH-1:0];
    bh = idata.b[MAX_WIDTH-1:HALF_WIDTH];
    dnum = idata.sgn ? idata.ma : idata.a;
    dden = idata.sgn ? idata.mb : idata.b;
    case (op_t'(idata.kind))
      OP_ADD: begin
        msum = (idata.a + idata.b) & idata.mask;
        s0.res = msum;
        if (idata.nuw) begin
          if ((idata.mask - idata.a) < idata.b) s0.unk = 1'b1;
        end else if (idata.nsw) begin
          if (idata.an == idata.bn && ((|(msum & ~(idata.mask >> 1))) != idata.an))
            s0.unk = 1'b1;
        end
      end
      OP_SUB: begin
        msum = (idata.a - idata.b) & idata.mask;
        s0.res = msum;
        if (idata.nuw) begin
          if (idata.b > idata.a) s0.unk = 1'b1;
        end else if (idata.nsw) begin
          if (idata.an != idata.bn && ((|(msum & ~(idata.mask >> 1))) != idata.an))
            s0.unk = 1'b1;
        end
      end
      OP_MUL: begin
        // Only the low word of the product is kept, so the high-by-high term drops out.
        s0.ismul = 1'b1;
        s0.res = MAX_WIDTH'(al) * MAX_WIDTH'(bl);
        s0.pc1 = al * bh;
        s0.pc2 = ah * bl;
        if (idata.nuw) begin
          lsum = (WW+1)'(bit_len_est(idata.a)) + (WW+1)'(bit_len_est(idata.b));
          if (lsum > (WW+1)'(idata.w)) s0.unk = 1'b1;
        end else if (idata.nsw) begin
          lsum = (WW+1)'(bit_len_est(idata.ma)) + (WW+1)'(bit_len_est(idata.mb));
          if (lsum > (WW+1)'(idata.w)) s0.unk = 1'b1;
        end
      end
      OP_DIV, OP_REM: begin
        s0.isdiv = 1'b1;
        s0.isquo = idata.kind == 4'(OP_DIV);
        s0.negq  = idata.sgn && (idata.an != idata.bn);
        s0.negr  = idata.sgn && idata.an;
        if (idata.b == '0) s0.unk = 1'b1;
      end
      OP_AND: s0.res = idata.a & idata.b;
      OP_OR:  s0.res = idata.a | idata.b;
      OP_XOR: s0.res = idata.a ^ idata.b;
      OP_SHL: s0.res = big ? '0 : ((idata.a << sh[WW-2:0]) & idata.mask);
      OP_SHR: begin
        if (big) s0.res = (idata.sgn && idata.an) ? idata.mask : '0;
        else begin
          s0.res = idata.a >> sh[WW-2:0];
          if (idata.sgn && idata.an)
            s0.res = s0.res | (idata.mask & ~(idata.mask >> sh[WW-2:0]));
        end
      end
      default: s0.unk = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= iv;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
    if (en) begin
      st[0] <= s0;
      for (int i = 1; i < NST-1; i++) st[i] <= st[i-1];
    end
  end

  // The divider's stages line up with st[1] .. st[MAX_WIDTH].
  logic [MAX_WIDTH-1:0] dnum_r, dden_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dnum_r <= dnum;
      dden_r <= (dden == '0) ? MAX_WIDTH'(1) : dden;
    end
  end

  wac_divider u_div (
    .clk(clk), .en(en), .num(dnum_r), .den(dden_r), .quo(quo), .rem(rem)
  );

  always_comb begin
    dres = st[NST-2].isquo ? quo : rem;
    if (st[NST-2].isquo ? st[NST-2].negq : st[NST-2].negr) dres = ~dres + MAX_WIDTH'(1);
    mres = st[NST-2].res + {st[NST-2].pc1 + st[NST-2].pc2, HALF_WIDTH'(0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oval <= st[NST-2].unk ? '0 :
              ((st[NST-2].isdiv ? dres : (st[NST-2].ismul ? mres : st[NST-2].res))
               & st[NST-2].mask);
      ounk <= st[NST-2].unk;
    end
  end

endmodule

// ===== sim/wac_result_checker.sv =====
// Checker for the width-aware ALU: watches both channels, computes the
// expected fold result for each input transfer and compares output transfers.
// Depends on wac_pkg for the opcode names.
`timescale 1ns / 1ps
module wac_result_checker import wac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [3:0]  kind,
  input  logic [63:0] lhs_value,
  input  logic [63:0] rhs_value,
  input  logic        lhs_known,
  input  logic        rhs_known,
  input  logic [6:0]  bit_width,
  input  logic        no_unsigned_wrap,
  input  logic        no_signed_wrap,
  input  logic        signed_mode,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result_value,
  input  logic        result_unknown,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0] value;
    logic        unknown;
  } fold_t;

  fold_t folds_due[$];

  function automatic int est_len(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    if (v == 64'd2) n = 1;
    return n;
  endfunction

  function automatic fold_t fold_op(logic [3:0] op, logic [63:0] lv, logic [63:0] rv,
                                    logic lk, logic rk, logic [6:0] bw,
                                    logic nuw, logic nsw, logic sgn);
    int unsigned w;
    logic [63:0] mask, sbit, a, b, ma, mb, res;
    logic an, bn, unk;
    fold_t f;
    w = bw;
    if (w < 1) w = 1;
    if (w > 64) w = 64;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
    sbit = 64'd1 << (w - 1);
    a = lv & mask;
    b = rv & mask;
    an = (a & sbit) != 0;
    bn = (b & sbit) != 0;
    ma = an ? ((-a) & mask) : a;
    mb = bn ? ((-b) & mask) : b;
    if (an && ma == 0) ma = sbit;
    if (bn && mb == 0) mb = sbit;
    res = '0;
    unk = 1'b0;
    if (!lk || !rk) begin
      unk = 1'b1;
    end else begin
      case (op)
        OP_ADD: begin
          res = (a + b) & mask;
          if (nuw) unk = (mask - a) < b;
          else if (nsw) unk = (an == bn) && (((res & sbit) != 0) != an);
        end
        OP_SUB: begin
          res = (a - b) & mask;
          if (nuw) unk = b > a;
          else if (nsw) unk = (an != bn) && (((res & sbit) != 0) != an);
        end
        OP_MUL: begin
          res = (a * b) & mask;
          if (nuw) unk = est_len(a) + est_len(b) > w;
          else if (nsw) unk = est_len(ma) + est_len(mb) > w;
        end
        OP_DIV, OP_REM: begin
          if (b == 0) begin
            unk = 1'b1;
          end else if (!sgn) begin
            res = (op == OP_DIV) ? a / b : a % b;
          end else if (op == OP_DIV) begin
            res = ma / mb;
            if (an != bn) res = -res;
            res &= mask;
          end else begin
            res = ma % mb;
            if (an) res = -res;
            res &= mask;
          end
        end
        OP_AND: res = a & b;
        OP_OR:  res = a | b;
        OP_XOR: res = a ^ b;
        OP_SHL: res = (b >= w) ? '0 : ((a << b) & mask);
        OP_SHR: begin
          if (b >= w) begin
            res = (sgn && an) ? mask : '0;
          end else begin
            res = a >> b;
            if (sgn && an && b > 0) res |= mask & ~(mask >> b);
          end
        end
        default: unk = 1'b1;
      endcase
    end
    f.value = unk ? '0 : (res & mask);
    f.unknown = unk;
    return f;
  endfunction

  assign pending = folds_due.size();

  always @(posedge clk) begin
    fold_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (valid && ready)
        folds_due.insert(folds_due.size(),
                         fold_op(kind, lhs_value, rhs_value, lhs_known, rhs_known,
                                 bit_width, no_unsigned_wrap, no_signed_wrap,
                                 signed_mode));
      if (out_valid && out_ready) begin
        if (folds_due.size() == 0) begin
          $display("%0t: result transfer with nothing expected: value %h unknown %b",
                   $time, result_value, result_unknown);
          fail_count <= fail_count + 1;
        end else begin
          want = folds_due.pop_front();
          if (want.value !== result_value || want.unknown !== result_unknown) begin
            $display("%0t: mismatch: expected value %h unknown %b, got value %h unknown %b",
                     $time, want.value, want.unknown, result_value, result_unknown);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/width_aware_alu_with_wrap_checks_top_test.sv =====
// Testbench top for the width-aware ALU: drives directed and random
// operations with random idling and a long output stall, then gives the verdict.
// Depends on wac_pkg, the block's RTL and wac_result_checker.
`timescale 1ns / 1ps
module width_aware_alu_with_wrap_checks_top_test;
  import wac_pkg::*;

  localparam int NUM_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_START = 800;
  localparam int QUIET_END = 1300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [3:0]  kind = '0;
  logic [63:0] lhs_value = '0;
  logic [63:0] rhs_value = '0;
  logic        lhs_known = 1'b0;
  logic        rhs_known = 1'b0;
  logic [6:0]  bit_width = 7'd1;
  logic        no_unsigned_wrap = 1'b0;
  logic        no_signed_wrap = 1'b0;
  logic        signed_mode = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_value;
  logic        result_unknown;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic        driving_done = 1'b0;
  int          stall_start;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  width_aware_alu_with_wrap_checks_top i_dut (.*);

  wac_result_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 70));
      4: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_op(logic [3:0] op, logic [63:0] lv, logic [63:0] rv, logic lk,
                         logic rk, logic [6:0] bw, logic nuw, logic nsw, logic sgn);
    // Random gaps, except in the quiet stretch of the run.
    while (cycle_count > QUIET_START && cycle_count < QUIET_END ? 1'b0 :
           $urandom_range(0, 99) < 24) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    kind <= op;
    lhs_value <= lv;
    rhs_value <= rv;
    lhs_known <= lk;
    rhs_known <= rk;
    bit_width <= bw;
    no_unsigned_wrap <= nuw;
    no_signed_wrap <= nsw;
    signed_mode <= sgn;
    do @(posedge clk); while (!ready);
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off early on, no stalls for a while.
  initial begin
    logic stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (40) @(negedge clk);
    out_ready <= 1'b0;
    for (stall_start = 0; stall_start < 300; stall_start++) @(negedge clk);
    forever begin
      stall = (cycle_count > QUIET_START && cycle_count < QUIET_END) ? 1'b0 :
              ($urandom_range(0, 99) < 24);
      out_ready <= !stall;
      @(negedge clk);
    end
  end

  initial begin
    logic [6:0] bw;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: each opcode at extremes, plus the special cases.
    send_op(OP_ADD, '1, 64'd1, 1'b1, 1'b1, 7'd64, 1'b1, 1'b0, 1'b0);
    send_op(OP_ADD, 64'h7f, 64'd1, 1'b1, 1'b1, 7'd8, 1'b0, 1'b1, 1'b0);
    send_op(OP_SUB, 64'h80, 64'd1, 1'b1, 1'b1, 7'd8, 1'b0, 1'b1, 1'b0);
    send_op(OP_SUB, 64'd0, 64'd1, 1'b1, 1'b1, 7'd16, 1'b1, 1'b1, 1'b0);
    send_op(OP_MUL, 64'd2, 64'd3, 1'b1, 1'b1, 7'd2, 1'b1, 1'b0, 1'b0);
    send_op(OP_MUL, 64'h80, 64'h80, 1'b1, 1'b1, 7'd8, 1'b0, 1'b1, 1'b0);
    send_op(OP_DIV, 64'h80, 64'hff, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_REM, 64'h80, 64'hff, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_DIV, 64'hf9, 64'd2, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_REM, 64'hf9, 64'd2, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_DIV, '1, 64'h100, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(OP_REM, '1, '1, 1'b1, 1'b1, 7'd64, 1'b0, 1'b0, 1'b0);
    send_op(OP_AND, '1, 64'h5555, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0, 1'b0);
    send_op(OP_OR, '1, '0, 1'b1, 1'b1, 7'd127, 1'b0, 1'b0, 1'b0);
    send_op(OP_XOR, '1, 64'h1234, 1'b1, 1'b1, 7'd100, 1'b0, 1'b0, 1'b0);
    send_op(OP_SHL, 64'd1, 64'd63, 1'b1, 1'b1, 7'd64, 1'b0, 1'b0, 1'b0);
    send_op(OP_SHL, 64'd1, 64'd8, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(OP_SHR, 64'h80, 64'd3, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_SHR, 64'h80, 64'd200, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b1);
    send_op(OP_SHR, 64'h80, 64'd9, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(4'd10, 64'd1, 64'd1, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(4'd15, 64'd1, 64'd1, 1'b1, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(OP_ADD, 64'd1, 64'd1, 1'b0, 1'b1, 7'd8, 1'b0, 1'b0, 1'b0);
    send_op(OP_ADD, 64'd1, 64'd1, 1'b1, 1'b0, 7'd8, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: bw = 7'($urandom_range(0, 127));
        1: bw = 7'd64;
        2: bw = 7'd1;
        default: bw = 7'($urandom_range(1, 64));
      endcase
      send_op(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9) : $urandom_range(10, 15)),
              pick_operand(), $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 70))
                                                         : pick_operand(),
              $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0, bw,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    end
    valid <= 1'b0;
    driving_done <= 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
